FILE: hdl/dtfs_pkg.sv
// ----------------------------------------------------------------------------
// dtfs_pkg
// Shared types, widths and command codes of the descending table floor search.
// ----------------------------------------------------------------------------
package dtfs_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);

  // fixed field widths
  localparam int KEY_W    = 64;
  localparam int ENTRY_W  = 10;
  localparam int LENGTH_W = 11;

  // item commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // datapath operations
  localparam logic [2:0] OP_NOP    = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_PROBE1 = 3'd2;
  localparam logic [2:0] OP_UPD1   = 3'd3;
  localparam logic [2:0] OP_LOADM  = 3'd4;
  localparam logic [2:0] OP_PROBE2 = 3'd5;
  localparam logic [2:0] OP_UPD2   = 3'd6;

  typedef struct packed {
    logic               cmd;
    logic [ENTRY_W-1:0] entry_index;
    logic [KEY_W-1:0]   key_value;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [ENTRY_W-1:0] result_index;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic [2:0] op;
    logic       out_load;
    logic       out_found;
  } dp_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic in_query;
    logic empty;
    logic key_above;
    logic lo_lt_hi;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: hdl/dtfs_datapath.sv
// ----------------------------------------------------------------------------
// dtfs_datapath
// Key memory, length register, search bounds and the output register.
// ----------------------------------------------------------------------------
module dtfs_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  dtfs_pkg::in_item_t in_data,
  input  logic               cfg_valid,
  input  logic [dtfs_pkg::LENGTH_W-1:0] cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dtfs_pkg::out_item_t out_data,
  input  dtfs_pkg::dp_ctrl_t ctrl,
  output dtfs_pkg::dp_stat_t stat
);
  import dtfs_pkg::*;

  logic [KEY_W-1:0]    mem [TABLE_DEPTH];
  logic [KEY_W-1:0]    rd_data;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [LENGTH_W-1:0] table_length;
  logic [LEN_W-1:0]    len_sat;
  logic [LEN_W-1:0]    len;
  logic [KEY_W-1:0]    key;
  logic [KEY_W-1:0]    m;
  logic [IDX_W-1:0]    lo;
  logic [IDX_W-1:0]    hi;
  logic [IDX_W-1:0]    mid;
  logic [IDX_W-1:0]    mid_up;
  logic [IDX_W-1:0]    mid_dn;
  logic [IDX_W:0]      span;

  // configuration register, always ready
  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= '0;
    end else if (cfg_valid) begin
      table_length <= cfg_data;
    end
  end

  // saturate length at the table depth
  assign len_sat = (32'(table_length) > TABLE_DEPTH) ? LEN_W'(TABLE_DEPTH)
                                                      : LEN_W'(table_length);

  // probe points of the two searches
  assign span   = {1'b0, hi} - {1'b0, lo} + (IDX_W+1)'(1);
  assign mid_up = lo + IDX_W'(span >> 1);
  assign mid_dn = lo + ((hi - lo) >> 1);

  // load transfer writes the memory
  assign wr_en = in_valid && (ctrl.op == OP_START) && (in_data.cmd == CMD_LOAD) &&
                 (32'(in_data.entry_index) < TABLE_DEPTH);

  // read address per operation
  always_comb begin
    unique case (ctrl.op)
      OP_PROBE1: rd_addr = (lo < hi) ? mid_up : lo;
      OP_PROBE2: rd_addr = mid_dn;
      default:   rd_addr = '0;
    endcase
  end

  // key memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IDX_W'(in_data.entry_index)] <= in_data.key_value;
    end
    rd_data <= mem[rd_addr];
  end

  // search registers
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_START: begin
        key <= in_data.key_value;
        len <= len_sat;
        lo  <= '0;
        hi  <= IDX_W'(len_sat - LEN_W'(1));
      end
      OP_PROBE1: begin
        mid <= mid_up;
      end
      OP_UPD1: begin
        if (rd_data >= key) begin
          lo <= mid;
        end else begin
          hi <= mid - IDX_W'(1);
        end
      end
      OP_LOADM: begin
        m  <= rd_data;
        hi <= lo;
        lo <= '0;
      end
      OP_PROBE2: begin
        mid <= mid_dn;
      end
      OP_UPD2: begin
        if (rd_data <= m) begin
          hi <= mid;
        end else begin
          lo <= mid + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_data.found        <= ctrl.out_found;
      out_data.result_index <= ctrl.out_found ? ENTRY_W'(lo) : '0;
    end
  end

  // status to the controller
  assign stat.in_query  = (in_data.cmd == CMD_QUERY);
  assign stat.empty     = (len == '0);
  assign stat.key_above = (key > rd_data);
  assign stat.lo_lt_hi  = (lo < hi);
  assign stat.out_busy  = out_valid && out_stall;

endmodule

FILE: hdl/dtfs_controller.sv
// ----------------------------------------------------------------------------
// dtfs_controller
// Sequencer for the two binary search passes of one query.
// ----------------------------------------------------------------------------
module dtfs_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  dtfs_pkg::dp_stat_t stat,
  output dtfs_pkg::dp_ctrl_t ctrl
);
  import dtfs_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHK0    = 4'd1;
  localparam logic [3:0] S_PROBE1  = 4'd2;
  localparam logic [3:0] S_UPD1    = 4'd3;
  localparam logic [3:0] S_LOADM   = 4'd4;
  localparam logic [3:0] S_PROBE2  = 4'd5;
  localparam logic [3:0] S_UPD2    = 4'd6;
  localparam logic [3:0] S_DONE_NF = 4'd7;
  localparam logic [3:0] S_DONE_OK = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = (state != S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next     = state;
    ctrl.op        = OP_NOP;
    ctrl.out_load  = 1'b0;
    ctrl.out_found = 1'b0;
    unique case (state)
      S_IDLE: begin
        ctrl.op = OP_START;
        if (in_valid && stat.in_query) begin
          state_next = S_CHK0;
        end
      end
      S_CHK0: begin
        // entry zero is on the read port now
        if (stat.empty || stat.key_above) begin
          state_next = S_DONE_NF;
        end else begin
          state_next = S_PROBE1;
        end
      end
      S_PROBE1: begin
        ctrl.op    = OP_PROBE1;
        state_next = stat.lo_lt_hi ? S_UPD1 : S_LOADM;
      end
      S_UPD1: begin
        ctrl.op    = OP_UPD1;
        state_next = S_PROBE1;
      end
      S_LOADM: begin
        ctrl.op    = OP_LOADM;
        state_next = S_PROBE2;
      end
      S_PROBE2: begin
        ctrl.op    = OP_PROBE2;
        state_next = stat.lo_lt_hi ? S_UPD2 : S_DONE_OK;
      end
      S_UPD2: begin
        ctrl.op    = OP_UPD2;
        state_next = S_PROBE2;
      end
      S_DONE_NF: begin
        if (!stat.out_busy) begin
          ctrl.out_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_DONE_OK: begin
        if (!stat.out_busy) begin
          ctrl.out_load  = 1'b1;
          ctrl.out_found = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hdl/descending_table_floor_search.sv
// ----------------------------------------------------------------------------
// descending_table_floor_search
// Floor search over a descending table of 64-bit keys.
// ----------------------------------------------------------------------------
// A load transfer writes one key, and the block stays ready for the next item.
// A query holds the input stalled until both passes are done and its result is
// registered as the sequencer returns to idle, so the result is shown in the
// same cycle as the next item can transfer. A query that is not found, on an
// empty table or a key above entry 0, goes from the entry zero check straight
// to its result. In each binary search pass a probe state issues a read to the
// key memory and an update state then uses the registered read data. A result
// waits in an output register, so the next item is taken while it is held; a
// later result waits in the sequencer for as long as the one before it is
// stalled. table_length is written through the cfg channel, which is always
// ready; write it only while no query is in flight.
// ----------------------------------------------------------------------------
module descending_table_floor_search (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dtfs_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dtfs_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dtfs_pkg::LENGTH_W-1:0] cfg_data
);
  import dtfs_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  // sequencer
  dtfs_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // memory and search registers
  dtfs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .ctrl      (ctrl),
    .stat      (stat)
  );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the descending table floor search.
// ----------------------------------------------------------------------------
// Loads keep a software copy of the key table in step with the block. Every
// accepted query is answered by the same two-pass binary search in the bench.
// Returned results are compared field by field, in order. Phases change the
// searched length while the block is idle: the empty table, a single entry,
// a table with duplicates, many small random tables (sorted, flat, unsorted),
// a sparse table searched at the full depth, and a length register above the
// depth. Both sides may pause in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module tb_top;
  import dtfs_pkg::*;

  localparam int SETTLE_CYCLES = 60;
  localparam int QUIET_LIMIT   = 2000;
  localparam int DEEP_FILL     = 32;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  // software copy of the table, search length and answers still owed
  class floor_search_checker;
    bit [KEY_W-1:0] key_copy [TABLE_DEPTH];
    int unsigned    search_len;
    out_item_t      pending_answers[$];
    int unsigned    mismatches;

    function new();
      search_len = 0;
      mismatches = 0;
    endfunction

    function void set_length(logic [LENGTH_W-1:0] len);
      search_len = (len > TABLE_DEPTH) ? TABLE_DEPTH : len;
    endfunction

    // leftmost index of the smallest stored key not below the given key
    function out_item_t floor_of_key(logic [KEY_W-1:0] key);
      out_item_t      answer;
      int unsigned    lo, hi, mid;
      bit [KEY_W-1:0] floor_key;
      answer = '0;
      if (search_len == 0 || key > key_copy[0]) return answer;
      // first pass: last index whose key is still >= the query key
      lo = 0;
      hi = search_len - 1;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        if (key_copy[mid] >= key) lo = mid;
        else hi = mid - 1;
      end
      floor_key = key_copy[lo];
      // second pass: first index at or below that key
      hi = lo;
      lo = 0;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (key_copy[mid] <= floor_key) hi = mid;
        else lo = mid + 1;
      end
      answer.found        = 1'b1;
      answer.result_index = lo[ENTRY_W-1:0];
      return answer;
    endfunction

    function void take_item(in_item_t item);
      if (item.cmd == CMD_LOAD) begin
        key_copy[item.entry_index] = item.key_value;
      end else begin
        pending_answers.push_back(floor_of_key(item.key_value));
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_answers.size() == 0) begin
        $display("%0t: result with no query waiting, expected none, actual found=%0b index=%0d",
                 $time, got.found, got.result_index);
        mismatches++;
        return;
      end
      want = pending_answers.pop_front();
      if (got.found !== want.found) begin
        $display("%0t: found mismatch, expected %0b, actual %0b",
                 $time, want.found, got.found);
        mismatches++;
      end
      if (got.result_index !== want.result_index) begin
        $display("%0t: result_index mismatch, expected %0d, actual %0d",
                 $time, want.result_index, got.result_index);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [LENGTH_W-1:0] cfg_data;

  floor_search_checker sb = new();
  bit [KEY_W-1:0]      shadow_keys [TABLE_DEPTH];
  bit                  sender_idle;
  bit                  receiver_idle;
  int unsigned         quiet_cycles = 0;

  descending_table_floor_search uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // observe every transfer on the three channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.take_item(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (cfg_valid && cfg_ready) sb.set_length(cfg_data);
    end
  end

  // give up when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side back-pressure in random bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (receiver_idle && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic bit [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // one item transfer, then maybe a gap
  task automatic send_item(input in_item_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (item.cmd == CMD_LOAD) shadow_keys[item.entry_index] = item.key_value;
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic load_entry(input int unsigned idx, input bit [KEY_W-1:0] key);
    in_item_t item;
    item.cmd         = CMD_LOAD;
    item.entry_index = idx[ENTRY_W-1:0];
    item.key_value   = key;
    send_item(item);
  endtask

  task automatic query_key(input bit [KEY_W-1:0] key);
    in_item_t item;
    item.cmd         = CMD_QUERY;
    item.entry_index = ENTRY_W'($urandom);
    item.key_value   = key;
    send_item(item);
  endtask

  // wait for every answer, then let a load or search finish inside the block
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input int unsigned len);
    cfg_valid <= 1'b1;
    cfg_data  <= len[LENGTH_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // shape 0..2: descending from the top, a random start or a narrow range
  // shape 3: values drawn from a pool of four, in no order
  task automatic fill_table(input int unsigned n, input int unsigned shape);
    bit [KEY_W-1:0] vals [TABLE_DEPTH];
    bit [KEY_W-1:0] pool [4];
    bit [KEY_W-1:0] v, span, step;
    int unsigned    start;
    for (int k = 0; k < 4; k++) pool[k] = rand_key();
    case (shape)
      0:       v = KEY_MAX;
      1:       v = rand_key();
      default: v = KEY_W'($urandom_range(0, 3 * n));
    endcase
    for (int i = 0; i < n; i++) begin
      if (shape == 3) begin
        vals[i] = pool[$urandom_range(0, 3)];
      end else begin
        vals[i] = v;
        span    = v / (n - i);
        step    = ($urandom_range(0, 3) == 0) ? '0 : 2 * (rand_key() % (span / 2 + 1));
        v       = v - step;
      end
    end
    // load in a rotated order
    start = $urandom_range(0, n - 1);
    for (int k = 0; k < n; k++) load_entry((start + k) % n, vals[(start + k) % n]);
  endtask

  // keys near stored values, extremes and keys above the first entry
  function automatic bit [KEY_W-1:0] pick_key(input int unsigned n);
    bit [KEY_W-1:0] s;
    s = shadow_keys[$urandom_range(0, n - 1)];
    case ($urandom_range(0, 7))
      0, 1:    return s;
      2:       return s + 1;
      3:       return s - 1;
      4:       return rand_key();
      5:       return '0;
      6:       return KEY_MAX;
      default: return shadow_keys[0] + 1;
    endcase
  endfunction

  task automatic run_phase(input int unsigned len, input int unsigned shape,
                           input int unsigned n_queries, input bit reload);
    int unsigned n;
    settle();
    write_length(len);
    n = (len > TABLE_DEPTH) ? TABLE_DEPTH : len;
    if (reload) fill_table(n, shape);
    repeat (n_queries) begin
      // occasional loads, mostly outside the searched range
      if ($urandom_range(0, 9) == 0) begin
        if (n < TABLE_DEPTH && $urandom_range(0, 2) != 0) begin
          load_entry($urandom_range(n, TABLE_DEPTH - 1), rand_key());
        end else begin
          load_entry($urandom_range(0, n - 1), rand_key());
        end
      end else begin
        query_key(pick_key(n));
      end
    end
  endtask

  // searched length at or above the depth over a sparse table: the low entries
  // are loaded and every first pass probe above them holds zero, so a nonzero
  // key keeps both passes on loaded entries
  task automatic run_deep_phase(input int unsigned len, input int unsigned shape,
                                input int unsigned n_queries, input bit reload);
    bit [KEY_W-1:0] key;
    settle();
    write_length(len);
    if (reload) begin
      fill_table(DEEP_FILL, shape);
      for (int s = DEEP_FILL; s < TABLE_DEPTH; s = s * 2) load_entry(s, '0);
    end
    repeat (n_queries) begin
      if ($urandom_range(0, 9) == 0) begin
        load_entry($urandom_range(0, DEEP_FILL - 1), rand_key());
      end else begin
        key = pick_key(DEEP_FILL);
        if (key == '0) key = 64'd1;
        query_key(key);
      end
    end
  endtask

  // main sequence
  initial begin
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    in_data       <= '0;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty table: never found, loads still land
    write_length(0);
    query_key('0);
    query_key(KEY_MAX);
    load_entry(TABLE_DEPTH - 1, '0);
    load_entry(0, KEY_MAX);
    query_key(KEY_MAX);
    query_key('0);

    // single entry, including sign-bit and nan patterns
    settle();
    write_length(1);
    query_key(KEY_MAX);
    query_key('0);
    load_entry(0, 64'h8000_0000_0000_0000);
    query_key(64'h8000_0000_0000_0001);
    query_key(64'h7FF8_0000_0000_0000);

    // duplicates, exact hits, key above the top, then an unsorted table
    settle();
    write_length(5);
    load_entry(0, 64'd90);
    load_entry(1, 64'd70);
    load_entry(2, 64'd70);
    load_entry(3, 64'd70);
    load_entry(4, 64'd10);
    query_key(64'd70);
    query_key(64'd71);
    query_key(64'd11);
    query_key(64'd10);
    query_key(64'd0);
    query_key(64'd91);
    load_entry(2, 64'd100);
    query_key(64'd50);

    // small random tables
    for (int p = 0; p < 8; p++) begin
      sender_idle   = ($urandom_range(0, 3) != 0);
      receiver_idle = ($urandom_range(0, 3) != 0);
      run_phase($urandom_range(1, 32), $urandom_range(0, 3), 35, 1'b1);
    end

    // full depth, then a length above the depth with no idling
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    run_deep_phase(TABLE_DEPTH, $urandom_range(0, 3), 60, 1'b1);
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    run_deep_phase((1 << LENGTH_W) - 1, 0, 60, 1'b0);

    settle();
    if (sb.mismatches == 0 && sb.pending_answers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
